@@ design/sacl_pkg.sv @@
`timescale 1ns / 1ps
package sacl_pkg;
  localparam int unsigned MaxSets = 256;
  localparam int unsigned MaxWays = 8;
  localparam int unsigned AddrWidth = 16;
  localparam int unsigned SetW = $clog2(MaxSets);
  localparam int unsigned WayW = $clog2(MaxWays);
  localparam int unsigned FillW = 4;
  localparam int unsigned CntW = 16;
  localparam int unsigned TotW = 32;

  localparam logic [1:0] RegAddrBits = 2'd0;
  localparam logic [1:0] RegSetBits = 2'd1;
  localparam logic [1:0] RegWordBits = 2'd2;
  localparam logic [1:0] RegWaysInUse = 2'd3;

  typedef logic [AddrWidth-1:0] tag_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef tag_t [MaxWays-1:0] tag_row_t;
  typedef cnt_t [MaxWays-1:0] cnt_row_t;

  // One row of the tag memory: the set's fill level beside its tags.
  typedef struct packed {
    logic [FillW-1:0] fill;
    tag_row_t         tags;
  } tag_ent_t;

  function automatic logic [TotW-1:0] sat_inc(input logic [TotW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction
endpackage

@@ design/set_assoc_cache_lfu_lookup_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_index_i, cfg_data_i
// request   in         in_valid/in_stall      address_i
// result    out        out_valid/out_stall    hit_o .. replace_count_o
// An access first reads the set row of the tag and use-count memories (one row
// holds all ways), then compares, picks the way and writes back.
// The next access enters right after the write-back, so no forwarding is needed.
// Fill levels share the tag row; a per-set flag cleared on reset marks written rows.
// A held result in the output register blocks new accesses only while stalled.
// A pending configuration beat takes priority and holds off new accesses.
module set_assoc_cache_lfu_lookup_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] address_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit_o,
  output logic [7:0]  set_index_o,
  output logic [2:0]  way_index_o,
  output logic        replaced_o,
  output logic [14:0] block_address_o,
  output logic [31:0] access_count_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] replace_count_o
);
  import sacl_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;

  logic [4:0] addr_bits_q;
  logic [3:0] set_bits_q;
  logic [1:0] word_bits_q;
  logic [3:0] ways_q;
  logic [1:0] state_q, state_d;
  logic [MaxSets-1:0] fill_vld_q;
  tag_ent_t tag_mem [MaxSets];
  cnt_row_t cnt_mem [MaxSets];
  tag_row_t tag_rd_q;
  cnt_row_t cnt_rd_q;
  logic [FillW-1:0] fill_rd_q;
  logic fill_seen_q;
  logic [SetW-1:0] set_q;
  tag_t tag_q;
  logic [14:0] block_q;
  logic [TotW-1:0] acc_q, hits_q, repl_q;

  // Field split of the incoming address.
  logic [4:0] ab;
  logic [3:0] sb;
  logic [1:0] wb;
  logic [AddrWidth-1:0] amask, addr_m, blk;
  logic [SetW-1:0] set_c;
  tag_t tag_c;
  always_comb begin
    ab = (addr_bits_q > 5'd16) ? 5'd16 : addr_bits_q;
    sb = (set_bits_q > 4'd8) ? 4'd8 : set_bits_q;
    wb = (word_bits_q == 2'd0) ? 2'd1 : word_bits_q;
    amask = (ab == 5'd16) ? '1 : AddrWidth'((17'd1 << ab) - 17'd1);
    addr_m = address_i & amask;
    blk = addr_m >> wb;
    set_c = SetW'(blk & AddrWidth'((9'd1 << sb) - 9'd1));
    tag_c = blk >> sb;
  end

  wire accept = in_valid && !in_stall;
  assign in_stall = (state_q != StIdle) || (out_valid && out_stall) || cfg_valid;
  assign cfg_ready = (state_q == StIdle);

  // Lookup stage.
  logic [3:0] ways, fill, search, fill_nx;
  logic hit_c, repl_c;
  logic [WayW-1:0] way_c, hway, lway;
  cnt_t least;
  always_comb begin
    ways = (ways_q == 4'd0) ? 4'd1 : ((ways_q > 4'd8) ? 4'd8 : ways_q);
    fill = fill_seen_q ? fill_rd_q : '0;
    search = (fill < ways) ? fill : ways;
    hit_c = 1'b0;
    hway = '0;
    for (int i = MaxWays - 1; i >= 0; i--) begin
      if (4'(i) < search && tag_rd_q[i] == tag_q) begin
        hit_c = 1'b1;
        hway = WayW'(i);
      end
    end
    least = cnt_rd_q[0];
    lway = '0;
    for (int i = 1; i < MaxWays; i++) begin
      if (4'(i) < ways && cnt_rd_q[i] < least) begin
        least = cnt_rd_q[i];
        lway = WayW'(i);
      end
    end
    repl_c = !hit_c && !(fill < ways);
    if (hit_c) way_c = hway;
    else if (fill < ways) way_c = WayW'(fill);
    else way_c = lway;
    fill_nx = (!hit_c && fill < ways) ? fill + 4'd1 : fill;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StLook;
      StLook: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      {fill_rd_q, tag_rd_q} <= tag_mem[set_c];
      cnt_rd_q <= cnt_mem[set_c];
      fill_seen_q <= fill_vld_q[set_c];
      set_q <= set_c;
      tag_q <= tag_c;
      block_q <= blk[14:0];
    end
    if (state_q == StLook) begin
      tag_row_t tr;
      cnt_row_t cr;
      tr = tag_rd_q;
      cr = cnt_rd_q;
      if (hit_c) begin
        if (!(&cr[way_c])) cr[way_c] = cr[way_c] + 1'b1;
      end else begin
        tr[way_c] = tag_q;
        cr[way_c] = cnt_t'(1);
      end
      tag_mem[set_q] <= {fill_nx, tr};
      cnt_mem[set_q] <= cr;
      set_index_o <= set_q;
      way_index_o <= way_c;
      hit_o <= hit_c;
      replaced_o <= repl_c;
      block_address_o <= block_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      addr_bits_q <= 5'd16;
      set_bits_q <= 4'd4;
      word_bits_q <= 2'd2;
      ways_q <= 4'd2;
      out_valid <= 1'b0;
      acc_q <= '0;
      hits_q <= '0;
      repl_q <= '0;
      fill_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          RegAddrBits: addr_bits_q <= cfg_data_i;
          RegSetBits: set_bits_q <= cfg_data_i[3:0];
          RegWordBits: word_bits_q <= cfg_data_i[1:0];
          RegWaysInUse: ways_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state_q == StLook) begin
        out_valid <= 1'b1;
        acc_q <= sat_inc(acc_q);
        if (hit_c) hits_q <= sat_inc(hits_q);
        if (repl_c) repl_q <= sat_inc(repl_q);
        fill_vld_q[set_q] <= 1'b1;
      end
    end
  end

  assign access_count_o = acc_q;
  assign hit_count_o = hits_q;
  assign replace_count_o = repl_q;

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |=> out_valid) else $error("result missing");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |-> !(out_valid && out_stall)) else $error("result overrun");
  a_hit_not_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(hit_o && replaced_o)) else $error("hit and replace");
  a_hits_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q <= acc_q) else $error("hit count above access count");
endmodule
